// File: src/mrkl_pkg.sv
package mrkl_pkg;

  typedef struct packed {
    logic        kind;
    logic [1:0]  word_index;
    logic [63:0] data_word;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] root_word;
    logic [1:0]  root_index;
    logic        root_last;
  } out_item_t;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_BRANCH = 1'b1;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// File: src/mrkl_sha_core.sv
// One SHA-256 compression, one round per cycle, rolling 16-word schedule.
module mrkl_sha_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] chain_in,
  input  logic [511:0] block_in,
  output logic         done,
  output logic [255:0] chain_out
);

  logic [31:0]  w_r [16];
  logic [31:0]  v_r [8];
  logic [31:0]  h_r [8];
  logic [5:0]   rnd_r;
  logic         busy_r;
  logic         done_r;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] s0w, s1w, w_new, s1, ch, t1, s0, maj, t2;

  always_comb begin
    s0w   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1w   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0w + w_r[9] + s1w;
    s1    = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + s1 + ch + mrkl_pkg::round_k(rnd_r) + w_r[0];
    s0    = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = s0 + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        for (int i = 0; i < 16; i++) w_r[i] <= block_in[511 - 32*i -: 32];
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= chain_in[255 - 32*i -: 32];
          h_r[i] <= chain_in[255 - 32*i -: 32];
        end
      end else if (busy_r) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        rnd_r  <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (done_r) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  // chain_out valid while done is high
  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[255 - 32*i -: 32] = h_r[i];
  end
  logic done_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_d_r <= 1'b0;
    else        done_d_r <= done_r;
  end
  assign done = done_d_r;

endmodule

// File: src/merkle_root_from_branch.sv
// Folds a Merkle branch onto a start hash with double SHA-256. Words come in as
// 64-bit pieces; a branch word with index 3 triggers three compressions on one
// shared round unit (64 rounds each), during which in_ready is low. Other
// words are stored without a compression. A word 3 with last set then emits
// the four root words, one per accepted out transfer.
module merkle_root_from_branch (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrkl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mrkl_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {S_IDLE, S_C1, S_C2, S_C3, S_EMIT} state_t;

  state_t       state_r;
  logic [63:0]  run_r [4];
  logic [63:0]  br_r  [4];
  logic         emit_after_r;
  logic [1:0]   oidx_r;
  logic         sha_start_r;
  logic [255:0] sha_chain_r;
  logic [511:0] sha_block_r;
  logic         sha_done;
  logic [255:0] sha_out;

  mrkl_sha_core u_sha (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sha_start_r),
    .chain_in (sha_chain_r),
    .block_in (sha_block_r),
    .done     (sha_done),
    .chain_out(sha_out)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_data.root_word  = run_r[oidx_r];
  assign out_data.root_index = oidx_r;
  assign out_data.root_last  = (oidx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sha_start_r  <= 1'b0;
      oidx_r       <= '0;
      emit_after_r <= 1'b0;
    end else begin
      sha_start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            emit_after_r <= in_data.last;
            oidx_r       <= '0;
            if (in_data.kind == mrkl_pkg::KIND_START) begin
              run_r[in_data.word_index] <= in_data.data_word;
              if (in_data.last && in_data.word_index == 2'd3) state_r <= S_EMIT;
            end else begin
              br_r[in_data.word_index] <= in_data.data_word;
              if (in_data.word_index == 2'd3) begin
                sha_chain_r <= mrkl_pkg::SHA_IV;
                sha_block_r <= {run_r[0], run_r[1], run_r[2], run_r[3],
                                br_r[0], br_r[1], br_r[2], in_data.data_word};
                sha_start_r <= 1'b1;
                state_r     <= S_C1;
              end
            end
          end
        end
        S_C1: begin
          if (sha_done) begin
            sha_chain_r <= sha_out;
            sha_block_r <= {32'h80000000, 416'd0, 64'd512};
            sha_start_r <= 1'b1;
            state_r     <= S_C2;
          end
        end
        S_C2: begin
          if (sha_done) begin
            sha_chain_r <= mrkl_pkg::SHA_IV;
            sha_block_r <= {sha_out, 32'h80000000, 160'd0, 64'd256};
            sha_start_r <= 1'b1;
            state_r     <= S_C3;
          end
        end
        S_C3: begin
          if (sha_done) begin
            for (int i = 0; i < 4; i++) run_r[i] <= sha_out[255 - 64*i -: 64];
            state_r <= emit_after_r ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 2'd1;
            if (oidx_r == 2'd3) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
